/* src/simple_moving_average_defines.svh */
// assertion macros shared by the moving average rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef SIMPLE_MOVING_AVERAGE_DEFINES_SVH
`define SIMPLE_MOVING_AVERAGE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SMA_ASSERT_IMPL(name, clock, resetn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SMA_ASSERT_NEXT(name, clock, resetn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/sma_pkg.sv */
// shared types and fixed constants for the moving average block
// no dependencies
`default_nettype none

package sma_pkg;

    // configuration register file
    localparam int WLEN_BITS  = 9;
    localparam int WLEN_RESET = 16;
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

    // register indexes (paddr word select)
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    // requests from the sequencer to the ring store
    typedef struct packed {
        logic rd;
        logic wr;
        logic clear;
    } sma_ring_ctrl_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } sma_div_stat_t;

endpackage

`default_nettype wire

/* src/sma_ring.sv */
// ring store of recent samples with write index and wrap flag
// depends on sma_pkg and simple_moving_average_defines.svh
`default_nettype none

module sma_ring #(
    parameter int DEPTH     = 256,
    parameter int DATA_BITS = 16,
    parameter int LEN_BITS  = 9
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sma_pkg::sma_ring_ctrl_t       ctrl,
    input  wire logic [LEN_BITS-1:0]           len,
    input  wire logic signed [DATA_BITS-1:0]   wr_data,
    output logic signed [DATA_BITS-1:0]        old_sample
);
    import sma_pkg::*;
    `include "simple_moving_average_defines.svh"

    localparam int IDX_BITS = $clog2(DEPTH);

    logic signed [DATA_BITS-1:0] mem [DEPTH];
    logic signed [DATA_BITS-1:0] rd_data_reg;
    logic [IDX_BITS-1:0]         idx_reg;
    logic [IDX_BITS-1:0]         idx_next;
    logic                        wrapped_reg;
    logic                        wrapped_next;
    logic [LEN_BITS:0]           idx_inc;
    logic                        wrap;

    // store contents are only trusted once the index has wrapped
    always_ff @(posedge clk)
    begin
        if (ctrl.rd)
        begin
            rd_data_reg <= mem[idx_reg];
        end
        if (ctrl.wr)
        begin
            mem[idx_reg] <= wr_data;
        end
    end

    assign idx_inc = (LEN_BITS+1)'(idx_reg) + (LEN_BITS+1)'(1);
    assign wrap    = idx_inc >= (LEN_BITS+1)'(len);

    always_comb
    begin
        idx_next     = idx_reg;
        wrapped_next = wrapped_reg;
        if (ctrl.clear)
        begin
            idx_next     = '0;
            wrapped_next = 1'b0;
        end
        else if (ctrl.wr)
        begin
            idx_next     = wrap ? '0 : IDX_BITS'(idx_inc);
            wrapped_next = wrapped_reg | wrap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            wrapped_reg <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            wrapped_reg <= wrapped_next;
        end
    end

    // unwritten slots read as zero
    assign old_sample = wrapped_reg ? rd_data_reg : '0;

    `SMA_ASSERT_IMPL(a_ring_idx_in_window, clk, rst_n, 1'b1,
        (LEN_BITS+1)'(idx_reg) < (LEN_BITS+1)'(len), "ring index outside window")

endmodule

`default_nettype wire

/* src/sma_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
// depends on sma_pkg and simple_moving_average_defines.svh
`default_nettype none

module sma_div #(
    parameter int DIVIDEND_BITS = 24,
    parameter int DIVISOR_BITS  = 9
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [DIVIDEND_BITS-1:0]  dividend,
    input  wire logic [DIVISOR_BITS-1:0]   divisor,
    output logic [DIVIDEND_BITS-1:0]       quotient,
    output sma_pkg::sma_div_stat_t         stat
);
    import sma_pkg::*;
    `include "simple_moving_average_defines.svh"

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  rem_next;
    logic [DIVISOR_BITS-1:0]  divisor_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic                     done_reg;
    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     fits;

    // dividend shifts out at the top, quotient bits shift in at the bottom
    assign trial    = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign diff     = trial - {1'b0, divisor_reg};
    assign fits     = trial >= {1'b0, divisor_reg};
    assign rem_next = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_BITS'(DIVIDEND_BITS);
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_BITS'(1));
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
            end
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = cnt_reg != '0;
    assign stat.done = done_reg;

    `SMA_ASSERT_IMPL(a_div_rem_below_divisor, clk, rst_n, stat.busy,
        rem_reg < divisor_reg, "partial remainder not below divisor")

endmodule

`default_nettype wire

/* src/simple_moving_average.sv */
// simple moving average over a ring store of the most recent samples
// depends on sma_pkg, sma_ring, sma_div and simple_moving_average_defines.svh
//
// usage
//   sample channel: sample with sample_valid / sample_stall; an item is taken
//     at a clock edge with sample_valid high and sample_stall low
//   average channel: average with average_valid / average_stall, held in an
//     output register so a new sample can be taken while a result waits
//   apb port: register 0 (byte address 0) is window_length, 9 bits; 0 acts
//     as 1 and values above MAX_WINDOW act as MAX_WINDOW; a write clears the
//     window (sum, write index and store), so write it only while idle
//   timing: a new sample is taken only once the previous one has left the
//     divider; the oldest sample is read at the accepting edge, then the
//     running sum is updated, the divider is loaded with the magnitude, the
//     bit-serial divider works out one quotient bit per bit of the running sum
//     (24 at the defaults) and the result lands in the output register
//   reset: window length 16, running sum and write index zero, store reads
//     as zero until the write index first wraps (no clearing pass)
//   stall: if average_stall holds the previous result, the finished
//     quotient waits in the divider and no new sample is taken meanwhile
`default_nettype none

module simple_moving_average #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // apb configuration
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [sma_pkg::PADDR_BITS-1:0]       paddr,
    input  wire logic [sma_pkg::PDATA_BITS-1:0]       pwdata,
    output logic [sma_pkg::PDATA_BITS-1:0]            prdata,
    output logic                                      pready,
    // sample items
    input  wire logic                                 sample_valid,
    output logic                                      sample_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]        sample,
    // average items
    output logic                                      average_valid,
    input  wire logic                                 average_stall,
    output logic signed [SAMPLE_BITS-1:0]             average
);
    import sma_pkg::*;
    `include "simple_moving_average_defines.svh"

    localparam int IDX_BITS  = $clog2(MAX_WINDOW);
    localparam int LEN_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + IDX_BITS;
    localparam int LEN_RESET = (WLEN_RESET > MAX_WINDOW) ? MAX_WINDOW : WLEN_RESET;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_HOLD = 3'd4;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;

    logic [WLEN_BITS-1:0]        wlen_reg;
    logic [LEN_BITS-1:0]         len_reg;
    logic [LEN_BITS-1:0]         len_clamped;
    logic [WLEN_BITS-1:0]        wlen_in;
    logic                        cfg_wr;
    logic                        cfg_len_wr;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] old_sample;
    logic signed [SUM_BITS-1:0]  sum_reg;
    logic signed [SUM_BITS-1:0]  sum_next;
    logic [SUM_BITS-1:0]         sum_mag;
    logic                        neg_reg;

    logic                        accept;
    logic                        out_free;
    logic                        load_out;
    logic                        out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] avg_reg;
    logic [SAMPLE_BITS-1:0]      quo_low;
    logic [SUM_BITS-1:0]         quotient;

    sma_ring_ctrl_t              ring_ctrl;
    sma_div_stat_t               div_stat;

    // ---------------- configuration port ----------------
    assign pready     = 1'b1;
    assign cfg_wr     = psel & penable & pwrite & pready;
    assign cfg_len_wr = cfg_wr & (paddr[PADDR_BITS-1] == REG_WINDOW_LENGTH);
    assign wlen_in    = pwdata[WLEN_BITS-1:0];
    assign prdata     = (paddr[PADDR_BITS-1] == REG_WINDOW_LENGTH) ?
                        PDATA_BITS'(wlen_reg) : '0;

    // zero means one, anything past the store depth saturates
    always_comb
    begin
        if (wlen_in == '0)
        begin
            len_clamped = LEN_BITS'(1);
        end
        else if (32'(wlen_in) > 32'(MAX_WINDOW))
        begin
            len_clamped = LEN_BITS'(MAX_WINDOW);
        end
        else
        begin
            len_clamped = LEN_BITS'(wlen_in);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= WLEN_BITS'(WLEN_RESET);
            len_reg  <= LEN_BITS'(LEN_RESET);
        end
        else if (cfg_len_wr)
        begin
            wlen_reg <= wlen_in;
            len_reg  <= len_clamped;
        end
    end

    // ---------------- sequencer ----------------
    assign sample_stall = (state_reg != ST_IDLE);
    assign accept       = sample_valid & ~sample_stall;
    assign out_free     = ~out_valid_reg | ~average_stall;
    assign load_out     = ((state_reg == ST_DIV) & div_stat.done & out_free) |
                          ((state_reg == ST_HOLD) & out_free);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // read the oldest slot on accept, overwrite it during the sum update
    assign ring_ctrl.rd    = accept;
    assign ring_ctrl.wr    = (state_reg == ST_UPD);
    assign ring_ctrl.clear = cfg_len_wr;

    sma_ring #(
        .DEPTH     (MAX_WINDOW),
        .DATA_BITS (SAMPLE_BITS),
        .LEN_BITS  (LEN_BITS)
    ) u_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ring_ctrl),
        .len        (len_reg),
        .wr_data    (sample_reg),
        .old_sample (old_sample)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
        end
    end

    // ---------------- running sum ----------------
    assign sum_next = sum_reg
                    + {{IDX_BITS{sample_reg[SAMPLE_BITS-1]}}, sample_reg}
                    - {{IDX_BITS{old_sample[SAMPLE_BITS-1]}}, old_sample};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (cfg_len_wr)
        begin
            sum_reg <= '0;
        end
        else if (state_reg == ST_UPD)
        begin
            sum_reg <= sum_next;
        end
    end

    // sign and magnitude so the divide truncates toward zero
    assign sum_mag = sum_reg[SUM_BITS-1] ? ('0 - SUM_BITS'(sum_reg)) : SUM_BITS'(sum_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            neg_reg <= sum_reg[SUM_BITS-1];
        end
    end

    sma_div #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (LEN_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_LOAD),
        .dividend (sum_mag),
        .divisor  (len_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // ---------------- output register ----------------
    // the quotient always fits the sample width, the negative extreme included
    assign quo_low = quotient[SAMPLE_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            avg_reg <= neg_reg ? SAMPLE_BITS'('0 - quo_low) : quo_low;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!average_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign average_valid = out_valid_reg;
    assign average       = avg_reg;

    `SMA_ASSERT_NEXT(a_accept_starts_update, clk, rst_n, accept,
        state_reg == ST_UPD, "accepted item did not start the sum update")
    `SMA_ASSERT_IMPL(a_div_busy_until_done, clk, rst_n,
        (state_reg == ST_DIV) && !div_stat.done, div_stat.busy,
        "divider idle while sequencer waits on it")
    `SMA_ASSERT_IMPL(a_len_in_range, clk, rst_n, 1'b1,
        (len_reg != '0) && (32'(len_reg) <= 32'(MAX_WINDOW)),
        "window length outside one to store depth")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// self-checking bench for simple_moving_average: random and directed samples, apb writes
// depends on sma_pkg and the simple_moving_average rtl; predicts every average itself
module tb_top;

    import sma_pkg::*;

    localparam int SMP_W       = 16;
    localparam int SUM_W       = 24;
    localparam int WINDOW_MAX  = 256;
    localparam int SETTLE      = 40;       // a little over the sample-to-average latency
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;

    // register map: word select in paddr[2], byte address 4*index
    localparam logic [PADDR_BITS-1:0] ADDR_WINDOW_LENGTH = {REG_WINDOW_LENGTH, 2'b00};
    localparam logic [PADDR_BITS-1:0] ADDR_SPARE         = {~REG_WINDOW_LENGTH, 2'b00};

    localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7fff;
    localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

    // block ports, all driven to known values from time zero
    logic                         clk;
    logic                         rst_n         = 1'b0;
    logic                         psel          = 1'b0;
    logic                         penable       = 1'b0;
    logic                         pwrite        = 1'b0;
    logic [PADDR_BITS-1:0]        paddr         = '0;
    logic [PDATA_BITS-1:0]        pwdata        = '0;
    logic [PDATA_BITS-1:0]        prdata;
    logic                         pready;
    logic                         sample_valid  = 1'b0;
    logic                         sample_stall;
    logic signed [SMP_W-1:0]      sample        = '0;
    logic                         average_valid;
    logic                         average_stall = 1'b0;
    logic signed [SMP_W-1:0]      average;

    // own copy of the window state
    logic signed [SMP_W-1:0]      win_store [WINDOW_MAX];
    logic signed [SUM_W-1:0]      win_sum;
    logic [7:0]                   win_index;
    logic [WLEN_BITS-1:0]         win_len;

    // traffic bookkeeping
    logic signed [SMP_W-1:0]      sample_feed [$];
    logic signed [SMP_W-1:0]      pending_averages [$];
    int unsigned                  samples_queued  = 0;
    int unsigned                  samples_offered = 0;
    int unsigned                  samples_taken   = 0;
    int unsigned                  averages_seen   = 0;
    int unsigned                  error_count     = 0;
    int unsigned                  cycle_count     = 0;
    int unsigned                  gap_left        = 0;
    int unsigned                  stall_left      = 0;
    int unsigned                  hold_left       = 0;
    bit                           hold_done       = 1'b0;
    bit                           calm            = 1'b0;

    simple_moving_average dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample        (sample),
        .average_valid (average_valid),
        .average_stall (average_stall),
        .average       (average)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // empties the ring, the sum and the write index, as reset and a length write do
    task automatic clear_window();
        for (int i = 0; i < WINDOW_MAX; i++)
            win_store[i] = '0;
        win_sum   = '0;
        win_index = '0;
    endtask

    // one step of the moving average: drop the oldest sample, add the new one,
    // then divide the exact sum by the length with truncation toward zero
    function automatic logic signed [SMP_W-1:0] next_average(input logic signed [SMP_W-1:0] s);
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] quo;
        win_sum = win_sum - win_store[win_index] + s;
        win_store[win_index] = s;
        if ({1'b0, win_index} + 9'd1 >= win_len)
            win_index = '0;
        else
            win_index = win_index + 8'd1;
        mag = win_sum[SUM_W-1] ? -win_sum : win_sum;
        quo = mag / SUM_W'(win_len);
        return win_sum[SUM_W-1] ? -quo[SMP_W-1:0] : quo[SMP_W-1:0];
    endfunction

    // biased towards the extremes and the region around zero
    function automatic logic signed [SMP_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return SMP_W'($signed($urandom_range(0, 8)) - 4);
            default: return SMP_W'($urandom);
        endcase
    endfunction

    task automatic push_item(input logic signed [SMP_W-1:0] s);
        sample_feed.push_back(s);
        samples_queued++;
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
            push_item(random_sample());
    endtask

    // every queued item taken and every average back, then let the pipe run dry
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (samples_taken != samples_queued || pending_averages.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // apb write: setup cycle, then access until pready; only called while idle
    task automatic apb_write(input logic [PADDR_BITS-1:0] addr, input logic [PDATA_BITS-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // only the window length register exists; any other word is ignored
        if (addr == ADDR_WINDOW_LENGTH)
        begin
            if (data[WLEN_BITS-1:0] == '0)
                win_len = 9'd1;
            else if (data[WLEN_BITS-1:0] > WINDOW_MAX)
                win_len = WLEN_BITS'(WINDOW_MAX);
            else
                win_len = data[WLEN_BITS-1:0];
            clear_window();
        end
    endtask

    // sender: holds an item until it is taken, idles in random bursts
    always @(negedge clk)
    begin
        if (rst_n && samples_offered == samples_taken)
        begin
            if (gap_left == 0 && !calm && sample_feed.size() != 0 && $urandom_range(0, 6) == 0)
                gap_left = $urandom_range(1, 11);
            if (gap_left != 0)
            begin
                sample_valid <= 1'b0;
                gap_left--;
            end
            else if (sample_feed.size() != 0)
            begin
                sample       <= sample_feed.pop_front();
                sample_valid <= 1'b1;
                samples_offered++;
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // receiver: random stall bursts, plus one long hold-off once traffic is flowing
    // so that the output register and the divider fill and the input stalls
    always @(negedge clk)
    begin
        if (!hold_done && !calm && averages_seen >= 300)
        begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (stall_left == 0 && hold_left == 0 && !calm && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 11);
        if (hold_left != 0)
        begin
            average_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_left != 0)
        begin
            average_stall <= 1'b1;
            stall_left--;
        end
        else
            average_stall <= 1'b0;
    end

    // handshakes seen at the rising edge: check averages, predict for samples taken
    always @(posedge clk)
    begin
        if (rst_n && average_valid && !average_stall)
        begin
            averages_seen++;
            if (pending_averages.size() == 0)
            begin
                $display("%0t: average %0d arrived with nothing expected", $time, average);
                error_count++;
            end
            else if (average !== pending_averages[0])
            begin
                $display("%0t: average mismatch, expected %0d, actual %0d",
                         $time, pending_averages[0], average);
                error_count++;
                void'(pending_averages.pop_front());
            end
            else
                void'(pending_averages.pop_front());
        end
        if (rst_n && sample_valid && !sample_stall)
        begin
            pending_averages.push_back(next_average(sample));
            samples_taken++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        win_len = WLEN_BITS'(WLEN_RESET);
        clear_window();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // reset length of 16 before any write: extremes and values around zero
        push_item(SMP_MAX);
        push_item(SMP_MAX);
        push_item(SMP_MIN);
        push_item(SMP_MIN);
        push_item(SMP_MIN);
        push_item(-16'sd1);
        push_item(16'sd1);
        push_item(16'sd0);
        push_item(-16'sd17);
        push_item(16'sd15);
        wait_quiet();

        // a write to an unused word must leave the window untouched
        apb_write(ADDR_SPARE, 32'd5);
        push_item(SMP_MIN);
        push_item(16'sh5555);
        push_item(16'shaaaa);
        push_item(-16'sd3);
        push_item(SMP_MAX);
        push_item(16'sd2);
        wait_quiet();

        // length zero acts as one
        apb_write(ADDR_WINDOW_LENGTH, 32'd0);
        push_item(SMP_MAX);
        push_item(SMP_MIN);
        push_item(-16'sd7);
        wait_quiet();

        apb_write(ADDR_WINDOW_LENGTH, 32'd1);
        push_item(16'sd9);
        push_item(-16'sd9);
        wait_quiet();

        // largest window, written exactly
        apb_write(ADDR_WINDOW_LENGTH, 32'(WINDOW_MAX));
        push_random(30);
        wait_quiet();

        // over-range length saturates; upper data bits are don't-care
        // full windows of each extreme drive the sum to both of its limits
        apb_write(ADDR_WINDOW_LENGTH, {23'($urandom), 9'h1ff});
        for (int i = 0; i < 260; i++)
            push_item(SMP_MIN);
        for (int i = 0; i < 260; i++)
            push_item(SMP_MAX);
        push_random(60);
        wait_quiet();

        // short windows that wrap many times
        repeat (4)
        begin
            apb_write(ADDR_WINDOW_LENGTH, 32'($urandom_range(2, 40)));
            push_random(100);
            wait_quiet();
        end

        apb_write(ADDR_WINDOW_LENGTH, 32'(WINDOW_MAX - 1));
        push_random(120);
        wait_quiet();

        // last stretch runs back to back with no idling on either side
        calm = 1'b1;
        apb_write(ADDR_WINDOW_LENGTH, 32'($urandom_range(2, 20)));
        push_random(150);
        wait_quiet();

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* simple_moving_average.f */
+incdir+src
src/sma_pkg.sv
src/sma_ring.sv
src/sma_div.sv
src/simple_moving_average.sv
tb/tb_top.sv
